// ----- src/bit_pack_encoder_defines.svh -----
// Assertion macros used by bpe_back.
`ifndef BIT_PACK_ENCODER_DEFINES_SVH
`define BIT_PACK_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS
`define BPE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define BPE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define BPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BPE_ASSERT(label, prop, msg)
`define BPE_ASSERT_IMP(label, ante, cons, msg)
`define BPE_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- src/bpe_pkg.sv -----
package bpe_pkg;

  localparam int WORD_BITS = 64;
  localparam int VALUE_BITS = 32;
  localparam int WIDTH_BITS = 6;
  localparam int FILL_BITS = 6;
  localparam int CMD_DEPTH_DEFAULT = 4;
  localparam int RES_DEPTH_DEFAULT = 4;

  localparam logic [WIDTH_BITS-1:0] USED_BITS_RESET = 6'd32;
  localparam logic [WIDTH_BITS-1:0] USED_BITS_MIN = 6'd1;
  localparam logic [WIDTH_BITS-1:0] USED_BITS_MAX = 6'd32;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  last_item;
  } item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] packed_word;
    logic                 final_word;
  } result_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [WIDTH_BITS-1:0] width;
    logic                  last;
  } cmd_t;

endpackage

// ----- src/bit_pack_encoder.sv -----
// Bit-packing encoder: each value is cut to its low used_bits bits (1 to 32; 0 reads as 1,
// larger settings as 32) and appended LSB-first into 64-bit words, earlier values in lower
// bits and values free to straddle two words. A word is delivered each time 64 bits fill up;
// the value marked last also delivers any partly filled word, zero in its unused high bits,
// and flags the final word of the stream, after which packing restarts from an empty word.
// One value is accepted per clock while the command queue has room. The back end writes one
// word per clock into the result queue while it has room; a last value that both completes a
// word and leaves a partial one writes the full word, then the partial one, taking no value
// in between. Write used_bits only between streams, once all words have been taken.
module bit_pack_encoder #(
  parameter int CMD_DEPTH = bpe_pkg::CMD_DEPTH_DEFAULT,
  parameter int RES_DEPTH = bpe_pkg::RES_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bpe_pkg::WIDTH_BITS-1:0] cfg_data,
  input  logic                           push,
  input  bpe_pkg::item_t                 item,
  output logic                           full,
  input  logic                           pop,
  output bpe_pkg::result_t               packed_out,
  output logic                           empty
);

  import bpe_pkg::*;

  cmd_t    cmd_in;
  cmd_t    cmd_out;
  logic    cmd_push;
  logic    cmd_full;
  logic    cmd_empty;
  logic    cmd_pop;
  result_t res_word;
  logic    res_push;
  logic    res_full;

  bpe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .push     (push),
    .item     (item),
    .full     (full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in),
    .cmd_full (cmd_full)
  );

  bpe_fifo #(
    .DEPTH(CMD_DEPTH),
    .WIDTH($bits(cmd_t))
  ) u_cmd_q (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_data(cmd_in),
    .full     (cmd_full),
    .pop      (cmd_pop),
    .pop_data (cmd_out),
    .empty    (cmd_empty)
  );

  bpe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_empty(cmd_empty),
    .cmd      (cmd_out),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_word (res_word)
  );

  bpe_fifo #(
    .DEPTH(RES_DEPTH),
    .WIDTH($bits(result_t))
  ) u_res_q (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .push_data(res_word),
    .full     (res_full),
    .pop      (pop),
    .pop_data (packed_out),
    .empty    (empty)
  );

endmodule

// ----- src/bpe_fifo.sv -----
module bpe_fifo #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW:0] CNT_FULL = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0] count;
  logic wr_en;
  logic rd_en;

  assign full = (count == CNT_FULL);
  assign empty = (count == '0);
  assign wr_en = push && !full;
  assign rd_en = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/bpe_front.sv -----
module bpe_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bpe_pkg::WIDTH_BITS-1:0] cfg_data,
  input  logic                          push,
  input  bpe_pkg::item_t                item,
  output logic                          full,
  output logic                          cmd_push,
  output bpe_pkg::cmd_t                 cmd,
  input  logic                          cmd_full
);

  import bpe_pkg::*;

  logic [WIDTH_BITS-1:0] used_bits;
  logic [WIDTH_BITS-1:0] width;
  logic [VALUE_BITS-1:0] mask;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      used_bits <= USED_BITS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      used_bits <= cfg_data;
    end
  end

  // Out-of-range widths saturate to the legal range.
  always_comb begin
    if (used_bits < USED_BITS_MIN) begin
      width = USED_BITS_MIN;
    end else if (used_bits > USED_BITS_MAX) begin
      width = USED_BITS_MAX;
    end else begin
      width = used_bits;
    end
  end

  assign mask = ~({VALUE_BITS{1'b1}} << width);

  assign full = cmd_full;
  assign cmd_push = push && !cmd_full;
  assign cmd.value = item.value & mask;
  assign cmd.width = width;
  assign cmd.last = item.last_item;

endmodule

// ----- src/bpe_back.sv -----
`include "bit_pack_encoder_defines.svh"

module bpe_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_empty,
  input  bpe_pkg::cmd_t   cmd,
  output logic            cmd_pop,
  input  logic            res_full,
  output logic            res_push,
  output bpe_pkg::result_t res_word
);

  import bpe_pkg::*;

  localparam int SH_BITS = WORD_BITS + VALUE_BITS;

  logic [WORD_BITS-1:0] acc;
  logic [WORD_BITS-1:0] acc_next;
  logic [FILL_BITS-1:0] fill;
  logic [FILL_BITS-1:0] fill_next;
  logic                 pend;
  logic                 pend_next;

  logic [SH_BITS-1:0]   shifted;
  logic [WORD_BITS-1:0] acc_or;
  logic [VALUE_BITS-1:0] carry;
  logic [FILL_BITS:0]   total;
  logic                 word_done;
  logic [FILL_BITS-1:0] rem;

  assign shifted = {{WORD_BITS{1'b0}}, cmd.value} << fill;
  assign acc_or = acc | shifted[WORD_BITS-1:0];
  assign carry = shifted[SH_BITS-1:WORD_BITS];
  assign total = {1'b0, fill} + {1'b0, cmd.width};
  assign word_done = total[FILL_BITS];
  assign rem = total[FILL_BITS-1:0];

  always_comb begin
    cmd_pop = 1'b0;
    res_push = 1'b0;
    res_word = '0;
    acc_next = acc;
    fill_next = fill;
    pend_next = pend;
    if (pend) begin
      if (!res_full) begin
        res_push = 1'b1;
        res_word.packed_word = acc;
        res_word.final_word = 1'b1;
        acc_next = '0;
        fill_next = '0;
        pend_next = 1'b0;
      end
    end else if (!cmd_empty && !res_full) begin
      cmd_pop = 1'b1;
      if (word_done) begin
        res_push = 1'b1;
        res_word.packed_word = acc_or;
        res_word.final_word = cmd.last && (rem == '0);
        acc_next = {{(WORD_BITS - VALUE_BITS){1'b0}}, carry};
        fill_next = rem;
        if (cmd.last) begin
          if (rem != '0) begin
            pend_next = 1'b1;
          end else begin
            acc_next = '0;
          end
        end
      end else if (cmd.last) begin
        res_push = 1'b1;
        res_word.packed_word = acc_or;
        res_word.final_word = 1'b1;
        acc_next = '0;
        fill_next = '0;
      end else begin
        acc_next = acc_or;
        fill_next = rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      fill <= '0;
      pend <= 1'b0;
    end else begin
      acc <= acc_next;
      fill <= fill_next;
      pend <= pend_next;
    end
  end

  `BPE_ASSERT_IMP(a_no_pop_during_flush, pend, !cmd_pop, "Command taken while a flush is pending")
  `BPE_ASSERT_NEXT(a_last_leaves_clean, cmd_pop && cmd.last, pend || (fill == '0 && acc == '0), "State not cleared after the last word")
  `BPE_ASSERT_NEXT(a_flush_clears, pend && !res_full, !pend && fill == '0 && acc == '0, "Flush did not return to the empty state")

endmodule

// ----- sim/bit_pack_encoder_tb.sv -----
module bit_pack_encoder_tb;
  import bpe_pkg::*;

  localparam int HALF_PERIOD = 2;
  localparam int RESET_CYCLES = 7;
  localparam int MAX_GAP = 8;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD = 160;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_ITEMS = 850;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [WIDTH_BITS-1:0] cfg_data = '0;
  logic push = 1'b0;
  item_t item = '0;
  logic full;
  logic pop = 1'b0;
  result_t packed_out;
  logic empty;

  item_t pending_values[$];
  result_t expected_words[$];

  logic [WIDTH_BITS-1:0] width_reg = USED_BITS_RESET;
  logic [WORD_BITS-1:0] pack_acc = '0;
  int pack_fill = 0;

  item_t cur_item = '0;
  bit send_busy = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;
  bit tx_fast = 1'b0;
  bit rx_fast = 1'b0;
  int words_taken = 0;
  int long_holds = 0;
  int fail_count = 0;

  bit_pack_encoder i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .push(push),
    .item(item),
    .full(full),
    .pop(pop),
    .packed_out(packed_out),
    .empty(empty)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic void note_failure(string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%s", what);
    end
  endfunction

  function automatic int unsigned live_width();
    if (width_reg < USED_BITS_MIN) begin
      return USED_BITS_MIN;
    end
    if (width_reg > USED_BITS_MAX) begin
      return USED_BITS_MAX;
    end
    return width_reg;
  endfunction

  // Appends a value to the running word and queues each word it completes or ends.
  function automatic void pack_value(item_t it);
    int unsigned w;
    int total;
    logic [WORD_BITS-1:0] v;
    result_t word;
    result_t tail;
    bit have_word;
    w = live_width();
    v = {32'd0, it.value} & ((64'd1 << w) - 64'd1);
    word = '0;
    have_word = 1'b0;
    pack_acc = pack_acc | (v << pack_fill);
    total = pack_fill + w;
    if (total >= WORD_BITS) begin
      word.packed_word = pack_acc;
      word.final_word = 1'b0;
      have_word = 1'b1;
      pack_fill = total - WORD_BITS;
      pack_acc = v >> (w - pack_fill);
    end else begin
      pack_fill = total;
    end
    if (it.last_item && have_word && pack_fill == 0) begin
      word.final_word = 1'b1;
    end
    if (have_word) begin
      expected_words.push_back(word);
    end
    if (it.last_item) begin
      if (pack_fill != 0) begin
        tail.packed_word = pack_acc;
        tail.final_word = 1'b1;
        expected_words.push_back(tail);
      end
      pack_acc = '0;
      pack_fill = 0;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && push && !full) begin
      pack_value(cur_item);
      send_busy = 1'b0;
      send_gap = tx_fast ? 0 : $urandom_range(0, MAX_GAP);
    end
  end

  always @(negedge clk) begin
    if (!rst && !send_busy) begin
      if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (pending_values.size() > 0) begin
        cur_item = pending_values.pop_front();
        send_busy = 1'b1;
        push <= 1'b1;
        item <= cur_item;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : take_word
    result_t want;
    if (!rst && pop && !empty) begin
      if (expected_words.size() == 0) begin
        note_failure($sformatf("unexpected word %h final %b",
                               packed_out.packed_word, packed_out.final_word));
      end else begin
        want = expected_words.pop_front();
        if (packed_out.packed_word !== want.packed_word ||
            packed_out.final_word !== want.final_word) begin
          note_failure($sformatf("mismatch: expected word %h final %b, got word %h final %b",
                                 want.packed_word, want.final_word,
                                 packed_out.packed_word, packed_out.final_word));
        end
      end
      words_taken++;
      // Hold off for a long stretch while plenty of values are still queued,
      // so that the block fills up and pushes back on its input.
      if (long_holds < 3 && pending_values.size() >= 24 &&
          words_taken >= 20 + 40 * long_holds) begin
        recv_gap = LONG_HOLD;
        long_holds++;
      end else begin
        recv_gap = rx_fast ? 0 : $urandom_range(0, MAX_GAP);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (recv_gap > 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic set_used_bits(logic [WIDTH_BITS-1:0] bits);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= bits;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    width_reg = bits;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send(logic [VALUE_BITS-1:0] v, logic last);
    item_t it;
    it.value = v;
    it.last_item = last;
    pending_values.push_back(it);
  endtask

  task automatic drain();
    while (pending_values.size() != 0 || send_busy || expected_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int n;
    int left;
    bit first;
    logic [WIDTH_BITS-1:0] bits;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset width: a stream ending exactly on a word boundary, then a lone value.
    send(32'hFFFF_FFFF, 1'b0);
    send(32'h0000_0000, 1'b0);
    send(32'hAAAA_AAAA, 1'b0);
    send(32'h5555_5555, 1'b1);
    send(32'h1234_5678, 1'b1);
    drain();

    // A width of zero reads as one bit.
    set_used_bits(6'd0);
    send(32'hFFFF_FFFF, 1'b0);
    send(32'hFFFF_FFFE, 1'b0);
    send(32'h0000_0001, 1'b0);
    send(32'h0000_0000, 1'b1);
    drain();

    // The largest setting saturates to 32 bits.
    set_used_bits(6'd63);
    send(32'hDEAD_BEEF, 1'b0);
    send(32'h8000_0000, 1'b0);
    send(32'hFFFF_FFFF, 1'b1);
    drain();

    // The last value completes a word and leaves a partial one behind.
    set_used_bits(6'd7);
    for (int i = 0; i < 10; i++) begin
      send(32'hFFFF_FFFF, i == 9);
    end
    drain();

    set_used_bits(USED_BITS_MIN);
    send(32'h0000_0001, 1'b1);
    drain();

    left = RANDOM_ITEMS;
    first = 1'b1;
    while (left > 0) begin
      // The first stream uses full-width values so that a long hold fills the block.
      if (first) begin
        bits = USED_BITS_MAX;
      end else begin
        case ($urandom_range(0, 7))
          0: bits = 6'd0;
          1: bits = 6'($urandom_range(33, 63));
          2: bits = USED_BITS_MAX;
          3: bits = USED_BITS_MIN;
          default: bits = 6'($urandom_range(1, 32));
        endcase
      end
      set_used_bits(bits);
      tx_fast = ($urandom_range(0, 3) == 0);
      rx_fast = ($urandom_range(0, 3) == 0);
      n = first ? 100 : $urandom_range(20, 100);
      if (n > left) begin
        n = left;
      end
      first = 1'b0;
      for (int i = 0; i < n; i++) begin
        send($urandom(), (i == n - 1) || ($urandom_range(0, 24) == 0));
      end
      left -= n;
      drain();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
